### sv/bhta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhta_pkg
// Shared types, codes and score helpers for the bucketed hash table.
// ----------------------------------------------------------------------------
package bhta_pkg;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_GENERATION     = 1'b0;
  localparam logic REG_MATE_THRESHOLD = 1'b1;

  localparam logic [1:0]  BOUND_EMPTY = 2'd0;
  localparam logic [1:0]  EXACT_BOUND = 2'd3;
  localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd31754;
  localparam logic signed [9:0] REFRESH_MARGIN = 10'sd4;
  localparam logic signed [8:0] DEPTH_FLOOR = -9'sd1;
  localparam logic signed [8:0] DEPTH_CEIL  = 9'sd127;

  // One way of a bucket as held in memory.
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [4:0]  gen;
    logic        pv;
    logic [1:0]  bound;
  } entry_t;

  typedef struct packed {
    logic latch;     // take a new item into the input registers
    logic sweep;     // write zeros at the sweep counter, advance it
    logic cmp_load;  // register the way choice and the result
    logic commit;    // write back the chosen way
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } status_t;

  // Convert a mate distance between root-relative and node-relative form.
  function automatic logic [15:0] mate_adjust(input logic signed [15:0] s,
                                              input logic [7:0] ply,
                                              input logic [14:0] thr,
                                              input logic to_table);
    logic signed [16:0] sw;
    logic signed [16:0] tw;
    logic signed [16:0] pw;
    logic signed [16:0] r;
    sw = {s[15], s};
    tw = {2'b00, thr};
    pw = {9'b0, ply};
    if (sw >= tw) begin
      r = to_table ? sw + pw : sw - pw;
    end else if (sw <= -tw) begin
      r = to_table ? sw - pw : sw + pw;
    end else begin
      r = sw;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

### sv/bhta_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhta_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bhta_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bhta_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhta_ctrl
// Sequencer: clearing sweep, bucket address, read, compare, write-back.
// ----------------------------------------------------------------------------
module bhta_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        opcode,
  input  wire bhta_pkg::status_t status,
  output bhta_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_RD,
    S_CMP,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   sweep_reply;
  logic   accept;

  assign accept = start & ~busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (status.sweep_last) begin
          state_next = sweep_reply ? S_FIN : S_IDLE;
        end
      end
      S_IDLE, S_FIN: begin
        if (accept) begin
          state_next = (opcode == bhta_pkg::OP_CLEAR) ? S_CLR : S_MUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL:   state_next = S_RD;
      S_RD:    state_next = S_CMP;
      S_CMP:   state_next = S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      sweep_reply <= 1'b0;
      busy        <= 1'b1;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        sweep_reply <= (opcode == bhta_pkg::OP_CLEAR);
      end
      busy <= !(state_next == S_IDLE || state_next == S_FIN);
      done <= (state_next == S_FIN);
    end
  end

  always_comb begin
    cmd.latch    = accept;
    cmd.sweep    = (state == S_CLR);
    cmd.cmp_load = (state == S_CMP);
    cmd.commit   = (state == S_FIN);
  end

endmodule
`default_nettype wire

### sv/bhta_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhta_dp
// Datapath: bucket index, way memories, probe match, replacement choice.
// ----------------------------------------------------------------------------
module bhta_dp #(
  parameter int BUCKET_COUNT = 1024,
  parameter int WAYS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bhta_pkg::cmd_t     cmd,
  output bhta_pkg::status_t       status,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic [1:0]         opcode,
  input  wire logic [63:0]        hash_key,
  input  wire logic [7:0]         ply,
  input  wire logic signed [8:0]  search_depth,
  input  wire logic [1:0]         bound_kind,
  input  wire logic [15:0]        best_move,
  input  wire logic signed [15:0] search_score,
  input  wire logic signed [15:0] static_eval,
  input  wire logic               on_pv,
  output logic                    hit,
  output logic [15:0]             found_move,
  output logic signed [15:0]      found_score,
  output logic signed [15:0]      found_eval,
  output logic signed [7:0]       found_depth,
  output logic [1:0]              found_bound,
  output logic                    found_pv
);

  localparam int NW = $clog2(BUCKET_COUNT + 1);
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int PW = 32 + NW;
  localparam int EW = $bits(bhta_pkg::entry_t);
  localparam logic [NW-1:0] N_L = NW'(BUCKET_COUNT);
  localparam logic [BW-1:0] LAST = BW'(BUCKET_COUNT - 1);

  logic [1:0]         op_q;
  logic [63:0]        key_q;
  logic [7:0]         ply_q;
  logic signed [8:0]  depth_q;
  logic [1:0]         bound_q;
  logic [15:0]        move_q;
  logic signed [15:0] score_q;
  logic [15:0]        eval_q;
  logic               pv_q;

  logic [4:0]  generation;
  logic [14:0] mate_threshold;

  logic [PW-1:0] prod_lo;
  logic [PW-1:0] prod_hi;
  logic [PW:0]   prod_sum;
  logic [BW-1:0] bucket;
  logic [BW-1:0] bucket_q;
  logic [BW-1:0] sweep_cnt;

  bhta_pkg::entry_t rdata [WAYS];
  bhta_pkg::entry_t wdata_q;
  logic [WAYS-1:0]  pick_q;

  // Compare stage results
  logic [WAYS-1:0]  pick_oh;
  bhta_pkg::entry_t sel;
  bhta_pkg::entry_t new_entry;
  bhta_pkg::entry_t probe_entry;
  logic             probe_hit;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= opcode;
      key_q   <= hash_key;
      ply_q   <= ply;
      depth_q <= search_depth;
      bound_q <= bound_kind;
      move_q  <= best_move;
      score_q <= search_score;
      eval_q  <= static_eval;
      pv_q    <= on_pv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generation     <= '0;
      mate_threshold <= bhta_pkg::MATE_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhta_pkg::REG_GENERATION:     generation     <= cfg_data[4:0];
        bhta_pkg::REG_MATE_THRESHOLD: mate_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bucket is the high word of key * BUCKET_COUNT, built from two half products.
  always_ff @(posedge clk) begin
    prod_lo  <= PW'(key_q[31:0]) * PW'(N_L);
    prod_hi  <= PW'(key_q[63:32]) * PW'(N_L);
    bucket_q <= bucket;
  end

  assign prod_sum = (PW + 1)'(prod_hi) + (PW + 1)'(prod_lo >> 32);
  assign bucket   = prod_sum[32 +: BW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + BW'(1);
    end else begin
      sweep_cnt <= '0;
    end
  end

  assign status.sweep_last = (sweep_cnt == LAST);

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [EW-1:0] rd_word;
    bhta_ram #(
      .WIDTH(EW),
      .DEPTH(BUCKET_COUNT)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.sweep | (cmd.commit & (op_q == bhta_pkg::OP_STORE) & pick_q[w])),
      .waddr(cmd.sweep ? sweep_cnt : bucket_q),
      .wdata(cmd.sweep ? '0 : wdata_q),
      .raddr(bucket),
      .rdata(rd_word)
    );
    assign rdata[w] = bhta_pkg::entry_t'(rd_word);
  end

  // Probe: first valid way with a matching tag.
  always_comb begin
    logic found;
    found       = 1'b0;
    probe_entry = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && rdata[w].bound != bhta_pkg::BOUND_EMPTY &&
          rdata[w].tag == key_q[15:0]) begin
        found       = 1'b1;
        probe_entry = rdata[w];
      end
    end
    probe_hit = found;
  end

  // Store: first way that is free or has the same tag, else least depth minus twice the age.
  always_comb begin
    logic               found;
    logic               have;
    logic               refresh;
    logic signed [8:0]  worth;
    logic signed [8:0]  worst;
    logic [4:0]         age;
    logic signed [9:0]  din4;
    logic signed [7:0]  dc;
    logic [15:0]        mv;
    found   = 1'b0;
    have    = 1'b0;
    refresh = 1'b0;
    worst   = '0;
    worth   = '0;
    age     = '0;
    pick_oh = '0;
    pick_oh[0] = 1'b1;
    din4    = $signed({depth_q[8], depth_q}) + bhta_pkg::REFRESH_MARGIN;
    for (int w = 0; w < WAYS; w++) begin
      if (!found) begin
        if (rdata[w].bound == bhta_pkg::BOUND_EMPTY) begin
          pick_oh    = '0;
          pick_oh[w] = 1'b1;
          found      = 1'b1;
        end else if (rdata[w].tag == key_q[15:0]) begin
          pick_oh    = '0;
          pick_oh[w] = 1'b1;
          found      = 1'b1;
          refresh    = (bound_q != bhta_pkg::EXACT_BOUND) &&
                       (din4 <= $signed({{2{rdata[w].depth[7]}}, rdata[w].depth}));
        end else begin
          age   = generation - rdata[w].gen;
          worth = $signed({rdata[w].depth[7], rdata[w].depth}) -
                  $signed({3'b000, age, 1'b0});
          if (!have || worth < worst) begin
            pick_oh    = '0;
            pick_oh[w] = 1'b1;
            worst      = worth;
            have       = 1'b1;
          end
        end
      end
    end

    sel = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (pick_oh[w]) begin
        sel = rdata[w];
      end
    end

    mv = (move_q == 16'd0 && sel.tag == key_q[15:0]) ? sel.move : move_q;
    if (depth_q < bhta_pkg::DEPTH_FLOOR) begin
      dc = bhta_pkg::DEPTH_FLOOR[7:0];
    end else if (depth_q > bhta_pkg::DEPTH_CEIL) begin
      dc = bhta_pkg::DEPTH_CEIL[7:0];
    end else begin
      dc = depth_q[7:0];
    end

    if (refresh) begin
      new_entry     = sel;
      new_entry.gen = generation;
    end else begin
      new_entry.tag   = key_q[15:0];
      new_entry.move  = mv;
      new_entry.score = bhta_pkg::mate_adjust(score_q, ply_q, mate_threshold, 1'b1);
      new_entry.eval  = eval_q;
      new_entry.depth = dc;
      new_entry.gen   = generation;
      new_entry.pv    = pv_q;
      new_entry.bound = bound_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_load) begin
      wdata_q <= new_entry;
      pick_q  <= pick_oh;
    end
  end

  // Result registers; zeroed during a sweep so a clear reports all zeros.
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      hit         <= 1'b0;
      found_move  <= '0;
      found_score <= '0;
      found_eval  <= '0;
      found_depth <= '0;
      found_bound <= '0;
      found_pv    <= 1'b0;
    end else if (cmd.cmp_load) begin
      if (op_q == bhta_pkg::OP_PROBE && probe_hit) begin
        hit         <= 1'b1;
        found_move  <= probe_entry.move;
        found_score <= bhta_pkg::mate_adjust(probe_entry.score, ply_q,
                                             mate_threshold, 1'b0);
        found_eval  <= probe_entry.eval;
        found_depth <= probe_entry.depth;
        found_bound <= probe_entry.bound;
        found_pv    <= probe_entry.pv;
      end else begin
        hit         <= 1'b0;
        found_move  <= '0;
        found_score <= '0;
        found_eval  <= '0;
        found_depth <= '0;
        found_bound <= '0;
        found_pv    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/bucketed_hash_table_with_aging_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_table_with_aging_top
// Set-associative table of search results with depth and age replacement.
// ----------------------------------------------------------------------------
// A probe or store steps through bucket product, memory read, way compare
// and write-back. The done strobe shows the result for one cycle, and start
// is taken again in that same cycle, so a new probe or store is taken only
// as the last one reports. The result cannot be held off; latch it when done
// is high. A clear, and the clearing pass after reset, writes one bucket
// (all ways at once) per cycle, with busy high until the sweep ends. After a
// clear, done follows in the next cycle; after reset no result is given.
// Configuration writes are accepted at any time, also during the sweep.
module bucketed_hash_table_with_aging_top #(
  parameter int BUCKET_COUNT = 1024,
  parameter int WAYS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [63:0]        hash_key,
  input  wire logic [7:0]         ply,
  input  wire logic signed [8:0]  search_depth,
  input  wire logic [1:0]         bound_kind,
  input  wire logic [15:0]        best_move,
  input  wire logic signed [15:0] search_score,
  input  wire logic signed [15:0] static_eval,
  input  wire logic               on_pv,
  output logic                    done,
  output logic                    hit,
  output logic [15:0]             found_move,
  output logic signed [15:0]      found_score,
  output logic signed [15:0]      found_eval,
  output logic signed [7:0]       found_depth,
  output logic [1:0]              found_bound,
  output logic                    found_pv
);

  bhta_pkg::cmd_t    cmd;
  bhta_pkg::status_t status;

  bhta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bhta_dp #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .WAYS        (WAYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .hash_key    (hash_key),
    .ply         (ply),
    .search_depth(search_depth),
    .bound_kind  (bound_kind),
    .best_move   (best_move),
    .search_score(search_score),
    .static_eval (static_eval),
    .on_pv       (on_pv),
    .hit         (hit),
    .found_move  (found_move),
    .found_score (found_score),
    .found_eval  (found_eval),
    .found_depth (found_depth),
    .found_bound (found_bound),
    .found_pv    (found_pv)
  );

  // A probe or store reports after the S_MUL, S_RD and S_CMP states.
  a_lookup_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode != bhta_pkg::OP_CLEAR) |-> ##4 done)
    else $error("probe or store result not on time");

  // A clear starts a sweep: busy and no result in the next cycle.
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == bhta_pkg::OP_CLEAR) |=> (busy && !done))
    else $error("clear did not start a sweep");

  // The result cycle is also a cycle that takes a new item.
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy during result cycle");

  // A write-back never overlaps the clearing sweep.
  a_sweep_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !(cmd.commit || cmd.cmp_load || done))
    else $error("sweep overlaps lookup");

endmodule
`default_nettype wire
